// ----- rtl/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master register access package
// Shared transaction types, operation codes, status codes and register
// indexes of the bit-level I2C register access master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_LOAD  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_BUSY  = 2'd1,
        ST_DONE  = 2'd2,
        ST_ERROR = 2'd3
    } t_status;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEVICE_ADDRESS   = 2'd0,
        CFG_REGISTER_ADDRESS = 2'd1,
        CFG_READ_MODE        = 2'd2,
        CFG_BYTE_COUNT       = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] load_index;
        logic [7:0] load_byte;
        logic       sda_level;
        logic       scl_level;
    } t_in_item;

    typedef struct packed {
        logic       scl_drive;
        logic       sda_drive;
        logic [1:0] transfer_status;
        logic       read_valid;
        logic [7:0] read_data;
        logic [3:0] read_index;
        logic       start_accepted;
    } t_out_item;

endpackage

// ----- rtl/i2c_master_register_access.sv -----
// ----------------------------------------------------------------------------
// I2C master register access
// Bit-level I2C master for register reads and writes, stepped one quarter of
// an SCL period per tick transaction.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i2cm_pkg::t_in_item
// out       output     o_out_valid / i_out_stall  i2cm_pkg::t_out_item
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// One transaction is taken per clock unless stalled; its result goes into the
// output register at the accepting edge and is offered from the next cycle.
// The transmit buffer read port is prefetched every cycle so that a data
// byte is ready at the first quarter of a write byte.
// Reset is synchronous and active low; the buffer keeps its contents.
// A stalled result holds the output register and stalls the input channel.
// ----------------------------------------------------------------------------
module i2c_master_register_access #(
    parameter int BUF_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  i2cm_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output i2cm_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_we,
    input  logic [i2cm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_ADDR_W  = 4'd1,
        PH_ACK1    = 4'd2,
        PH_REG     = 4'd3,
        PH_ACK2    = 4'd4,
        PH_RESTART = 4'd5,
        PH_ADDR_R  = 4'd6,
        PH_ACK3    = 4'd7,
        PH_READ    = 4'd8,
        PH_MACK    = 4'd9,
        PH_NACK    = 4'd10,
        PH_STOP    = 4'd11,
        PH_WRITE   = 4'd12,
        PH_ACK4    = 4'd13
    } t_phase;

    logic [6:0]  r_dev_addr;
    logic [7:0]  r_reg_addr;
    logic        r_read_mode;
    logic [4:0]  r_byte_count;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_q, n_q;
    logic        r_ack, n_ack;
    logic [7:0]  r_shift, n_shift;
    logic [4:0]  r_br, n_br;
    logic [4:0]  r_bw, n_bw;
    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic        r_err, n_err;
    logic        r_active, n_active;
    logic [1:0]  r_status, n_status;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;

    logic        r_out_valid;
    i2cm_pkg::t_out_item r_out, n_out;

    logic [7:0]  tx_mem [BUF_DEPTH];
    logic [7:0]  r_tx_rd;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic        wr_en;
    logic        accept;

    logic        rd_valid;
    logic [7:0]  rd_data;
    logic [3:0]  rd_index;
    logic        started;
    logic [7:0]  sv;
    logic [4:0]  br_inc;
    logic        is_start;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign wr_addr = IDX_W'(i_in.load_index);
    assign wr_en   = accept && (i_in.operation == i2cm_pkg::OP_LOAD)
                     && (32'(i_in.load_index) < BUF_DEPTH);
    assign rd_addr = accept ? n_ptr : r_ptr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            tx_mem[wr_addr] <= i_in.load_byte;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            r_tx_rd <= i_in.load_byte;
        end else begin
            r_tx_rd <= tx_mem[rd_addr];
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_q      = r_q;
        n_ack    = r_ack;
        n_shift  = r_shift;
        n_br     = r_br;
        n_bw     = r_bw;
        n_ptr    = r_ptr;
        n_err    = r_err;
        n_active = r_active;
        n_status = r_status;
        n_scl    = r_scl;
        n_sda    = r_sda;
        rd_valid = 1'b0;
        rd_data  = 8'd0;
        rd_index = 4'd0;
        started  = 1'b0;
        sv       = r_shift;
        br_inc   = r_br + 5'd1;
        is_start = (r_phase == PH_START) || (r_phase == PH_RESTART);

        case (i_in.operation)
            i2cm_pkg::OP_TICK: begin
                if (r_active && !(r_scl && !i_in.scl_level)) begin
                    case (r_phase)
                        PH_ADDR_W, PH_REG, PH_ADDR_R, PH_WRITE: begin
                            n_q = r_q + 5'd1;
                            case (r_q[1:0])
                                2'd0: begin
                                    if (r_q == 5'd0) begin
                                        case (r_phase)
                                            PH_ADDR_W: sv = {r_dev_addr, 1'b0};
                                            PH_REG:    sv = r_reg_addr;
                                            PH_ADDR_R: sv = {r_dev_addr, 1'b1};
                                            default:   sv = r_tx_rd;
                                        endcase
                                    end
                                    n_shift = sv;
                                    n_sda   = sv[3'd7 - r_q[4:2]];
                                end
                                2'd1: begin
                                    n_scl = 1'b1;
                                end
                                2'd2: begin
                                end
                                default: begin
                                    n_scl = 1'b0;
                                    if (r_q == 5'd31) begin
                                        if (r_phase == PH_WRITE) begin
                                            n_bw = r_bw + 5'd1;
                                            if (r_bw == 5'd31 ||
                                                r_ptr == IDX_W'(BUF_DEPTH - 1)) begin
                                                n_ptr = '0;
                                            end else begin
                                                n_ptr = r_ptr + IDX_W'(1);
                                            end
                                        end
                                        n_q     = 5'd0;
                                        n_phase = t_phase'(r_phase + 4'd1);
                                    end
                                end
                            endcase
                        end
                        PH_READ: begin
                            n_q = r_q + 5'd1;
                            case (r_q[1:0])
                                2'd0: begin
                                    if (r_q == 5'd0) begin
                                        n_shift = 8'd0;
                                        n_sda   = 1'b1;
                                    end
                                end
                                2'd1: begin
                                    n_scl = 1'b1;
                                end
                                2'd2: begin
                                    n_shift = r_shift |
                                        (8'(i_in.sda_level) << (3'd7 - r_q[4:2]));
                                end
                                default: begin
                                    n_scl = 1'b0;
                                    if (r_q == 5'd31) begin
                                        rd_valid = 1'b1;
                                        rd_data  = r_shift;
                                        rd_index = r_br[3:0];
                                        if (br_inc >= r_byte_count) begin
                                            n_phase = PH_NACK;
                                            n_br    = 5'd0;
                                        end else begin
                                            n_phase = PH_MACK;
                                            n_br    = br_inc;
                                        end
                                        n_q = 5'd0;
                                    end
                                end
                            endcase
                        end
                        PH_START, PH_RESTART, PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4,
                        PH_MACK, PH_NACK, PH_STOP: begin
                            n_q = r_q + 5'd1;
                            case (r_q[1:0])
                                2'd0: begin
                                    n_sda = !((r_phase == PH_MACK) ||
                                              (r_phase == PH_STOP));
                                end
                                2'd1: begin
                                    n_scl = 1'b1;
                                end
                                2'd2: begin
                                    if (is_start) begin
                                        n_sda = 1'b0;
                                    end else if (r_phase == PH_STOP) begin
                                        n_sda = 1'b1;
                                    end else if (r_phase != PH_MACK) begin
                                        n_ack = !i_in.sda_level;
                                    end
                                end
                                default: begin
                                    n_q = 5'd0;
                                    if (r_phase == PH_STOP) begin
                                        n_br     = 5'd0;
                                        n_bw     = 5'd0;
                                        n_ptr    = '0;
                                        n_phase  = PH_START;
                                        n_active = 1'b0;
                                        n_status = r_err ? i2cm_pkg::ST_ERROR
                                                         : i2cm_pkg::ST_DONE;
                                    end else begin
                                        n_scl = 1'b0;
                                        if (is_start) begin
                                            n_phase = t_phase'(r_phase + 4'd1);
                                        end else if (r_phase == PH_MACK) begin
                                            n_phase = PH_READ;
                                        end else if (r_phase == PH_NACK) begin
                                            n_phase = PH_STOP;
                                            if (r_ack) begin
                                                n_err = 1'b1;
                                            end
                                        end else if (!r_ack) begin
                                            n_phase = PH_STOP;
                                            n_err   = 1'b1;
                                        end else if (r_phase == PH_ACK4 && r_read_mode) begin
                                            n_phase = PH_STOP;
                                        end else if (!r_read_mode && r_phase != PH_ACK1) begin
                                            n_phase = (r_bw < r_byte_count) ? PH_WRITE
                                                                            : PH_STOP;
                                        end else begin
                                            n_phase = t_phase'(r_phase + 4'd1);
                                        end
                                    end
                                end
                            endcase
                        end
                        default: begin
                            n_phase = PH_STOP;
                            n_q     = 5'd0;
                        end
                    endcase
                end
            end
            i2cm_pkg::OP_START: begin
                if (!r_active) begin
                    n_active = 1'b1;
                    n_err    = 1'b0;
                    n_status = i2cm_pkg::ST_BUSY;
                    started  = 1'b1;
                end
            end
            default: begin
            end
        endcase

        n_out.scl_drive       = n_scl;
        n_out.sda_drive       = n_sda;
        n_out.transfer_status = n_status;
        n_out.read_valid      = rd_valid;
        n_out.read_data       = rd_data;
        n_out.read_index      = rd_index;
        n_out.start_accepted  = started;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr   <= 7'd0;
            r_reg_addr   <= 8'd0;
            r_read_mode  <= 1'b0;
            r_byte_count <= 5'd1;
            r_phase      <= PH_START;
            r_q          <= 5'd0;
            r_ack        <= 1'b0;
            r_shift      <= 8'd0;
            r_br         <= 5'd0;
            r_bw         <= 5'd0;
            r_ptr        <= '0;
            r_err        <= 1'b0;
            r_active     <= 1'b0;
            r_status     <= i2cm_pkg::ST_IDLE;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    i2cm_pkg::CFG_DEVICE_ADDRESS:   r_dev_addr   <= i_cfg_data[6:0];
                    i2cm_pkg::CFG_REGISTER_ADDRESS: r_reg_addr   <= i_cfg_data[7:0];
                    i2cm_pkg::CFG_READ_MODE:        r_read_mode  <= i_cfg_data[0];
                    i2cm_pkg::CFG_BYTE_COUNT:       r_byte_count <= i_cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_phase     <= n_phase;
                r_q         <= n_q;
                r_ack       <= n_ack;
                r_shift     <= n_shift;
                r_br        <= n_br;
                r_bw        <= n_bw;
                r_ptr       <= n_ptr;
                r_err       <= n_err;
                r_active    <= n_active;
                r_status    <= n_status;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- rtl/i2cm_reg_checker.sv -----
// ----------------------------------------------------------------------------
// I2C master register access checker
// Port-level assertions on result transactions of the register access master.
// ----------------------------------------------------------------------------
module i2cm_reg_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  i2cm_pkg::t_out_item  o_out
);

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.start_accepted)
        |-> (o_out.transfer_status == i2cm_pkg::ST_BUSY))
        else $error("Accepted start does not report busy status.");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.read_valid)
        |-> (o_out.transfer_status == i2cm_pkg::ST_BUSY
             && !o_out.start_accepted))
        else $error("Received byte outside a busy transfer.");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.read_valid)
        |-> (o_out.read_data == 8'd0 && o_out.read_index == 4'd0))
        else $error("Read fields are not zero without a received byte.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("Stalled result transaction changed.");

endmodule

bind i2c_master_register_access i2cm_reg_checker u_i2cm_reg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
